FILE: rtl/core/itda_pkg.sv
`timescale 1ns / 1ps

package itda_pkg;

   localparam int unsigned REQ_VALUE_WIDTH = 64;
   localparam int unsigned CHAR_WIDTH      = 8;

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'd45;

   localparam logic MODE_UNSIGNED = 1'b0;
   localparam logic MODE_SIGNED   = 1'b1;

   typedef struct packed {
      logic [REQ_VALUE_WIDTH-1:0] value;
      logic                       mode;
   } itda_req_type;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] character;
      logic                  last;
   } itda_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIGN,
      ST_SKIP,
      ST_EMIT
   } itda_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic convert;
      logic shift_digit;
      logic emit_sign;
   } itda_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic negative;
      logic top_digit_zero;
   } itda_status_type;

endpackage

FILE: rtl/core/itda_datapath.sv
`timescale 1ns / 1ps

module itda_datapath
   import itda_pkg::*;
#(
   parameter int unsigned VALUE_WIDTH = 64,
   parameter int unsigned NUM_DIGITS  = 20
) (
   input  logic                  clock,
   input  itda_req_type          req_payload,
   input  itda_cmd_type          cmd,
   output itda_status_type       status,
   output logic [CHAR_WIDTH-1:0] character
);

   localparam int unsigned BCD_WIDTH = 4 * NUM_DIGITS;

   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_WIDTH-1:0]   bcd_ff, bcd_in;
   logic                   neg_ff, neg_in;

   logic [VALUE_WIDTH-1:0] raw_value;
   logic [VALUE_WIDTH-1:0] magnitude;
   logic                   raw_negative;
   logic [BCD_WIDTH-1:0]   bcd_adj;
   logic [3:0]             top_digit;

   assign raw_value    = req_payload.value[VALUE_WIDTH-1:0];
   assign raw_negative = (req_payload.mode == MODE_SIGNED) && raw_value[VALUE_WIDTH-1];
   // unsigned negation, so the most negative value comes out right
   assign magnitude    = raw_negative ? ({VALUE_WIDTH{1'b0}} - raw_value) : raw_value;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      neg_in = neg_ff;
      if (cmd.load) begin
         bin_in = magnitude;
         bcd_in = '0;
         neg_in = raw_negative;
      end else if (cmd.convert) begin
         bcd_in = {bcd_adj[BCD_WIDTH-2:0], bin_ff[VALUE_WIDTH-1]};
         bin_in = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
      end else if (cmd.shift_digit) begin
         bcd_in = {bcd_ff[BCD_WIDTH-5:0], 4'b0000};
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      neg_ff <= neg_in;
   end

   assign top_digit             = bcd_ff[BCD_WIDTH-1 -: 4];
   assign status.negative       = neg_ff;
   assign status.top_digit_zero = (top_digit == 4'd0);
   assign character = cmd.emit_sign ? CHAR_MINUS : (CHAR_ZERO + {4'b0000, top_digit});

endmodule

FILE: rtl/core/itda_ctrl.sv
`timescale 1ns / 1ps

module itda_ctrl
   import itda_pkg::*;
#(
   parameter int unsigned VALUE_WIDTH = 64,
   parameter int unsigned NUM_DIGITS  = 20
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  itda_status_type status,
   output itda_cmd_type    cmd,
   output logic            busy,
   output logic            rsp_strobe,
   output logic            rsp_last
);

   localparam int unsigned BIT_CNT_WIDTH = $clog2(VALUE_WIDTH);
   localparam int unsigned DIG_CNT_WIDTH = $clog2(NUM_DIGITS + 1);

   itda_state_type           state_ff, state_in;
   logic [BIT_CNT_WIDTH-1:0] bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_WIDTH-1:0] dig_cnt_ff, dig_cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         bit_cnt_ff <= '0;
         dig_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         bit_cnt_ff <= bit_cnt_in;
         dig_cnt_ff <= dig_cnt_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      bit_cnt_in      = bit_cnt_ff;
      dig_cnt_in      = dig_cnt_ff;
      cmd             = '0;
      busy            = 1'b1;
      rsp_strobe      = 1'b0;
      rsp_last        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load   = 1'b1;
               bit_cnt_in = BIT_CNT_WIDTH'(VALUE_WIDTH - 1);
               dig_cnt_in = DIG_CNT_WIDTH'(NUM_DIGITS);
               state_in   = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.convert = 1'b1;
            if (bit_cnt_ff == '0) begin
               state_in = status.negative ? ST_SIGN : ST_SKIP;
            end else begin
               bit_cnt_in = bit_cnt_ff - 1'b1;
            end
         end
         ST_SIGN: begin
            cmd.emit_sign = 1'b1;
            rsp_strobe    = 1'b1;
            state_in      = ST_SKIP;
         end
         ST_SKIP: begin
            // drop leading zeros, keep at least one digit
            if (status.top_digit_zero && (dig_cnt_ff > DIG_CNT_WIDTH'(1))) begin
               cmd.shift_digit = 1'b1;
               dig_cnt_in      = dig_cnt_ff - 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_strobe      = 1'b1;
            cmd.shift_digit = 1'b1;
            dig_cnt_in      = dig_cnt_ff - 1'b1;
            if (dig_cnt_ff == DIG_CNT_WIDTH'(1)) begin
               rsp_last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/core/integer_to_decimal_ascii_unit.sv
`timescale 1ns / 1ps

// Binary to decimal ASCII converter. Pulse start while busy is low to hand
// over one value (the transfer happens on that edge); the block then streams
// the decimal text of the low VALUE_WIDTH bits, most significant digit first,
// one character per rsp_strobe cycle, with a leading '-' for a negative value
// in signed mode and last set on the final digit. Zero gives a single '0'.
// The receiver cannot stall: every strobed character must be taken in the
// cycle it appears. Busy stays high for each value through VALUE_WIDTH
// shift-and-add-3 steps of the BCD converter, then a minus sign when one is
// sent, then, for each BCD digit position, a step either to drop a leading
// zero or to send a digit, plus one step to leave the zero skip.
module integer_to_decimal_ascii_unit
   import itda_pkg::*;
#(
   parameter int unsigned VALUE_WIDTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  itda_req_type req_payload,
   output logic         rsp_strobe,
   output itda_rsp_type rsp_payload
);

   // digits needed for the widest unsigned value: floor(W * log10(2)) + 1
   localparam int unsigned NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;

   itda_cmd_type          cmd;
   itda_status_type       status;
   logic [CHAR_WIDTH-1:0] character;
   logic                  rsp_last;

   // sequencer: counts conversion steps and digits, drives the datapath
   itda_ctrl #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .NUM_DIGITS  (NUM_DIGITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_last   (rsp_last)
   );

   // magnitude, BCD shift register and character forming
   itda_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .NUM_DIGITS  (NUM_DIGITS)
   ) u_datapath (
      .clock       (clock),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .character   (character)
   );

   assign rsp_payload.character = character;
   assign rsp_payload.last      = rsp_last;

endmodule

FILE: rtl/core/itda_checker.sv
`timescale 1ns / 1ps

module itda_checker
   import itda_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input logic         rsp_strobe,
   input itda_rsp_type rsp_payload
);

   // a transfer starts a conversion
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("transfer did not raise busy");

   // characters only appear while a value is in progress
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("character strobed while idle");

   // the final character ends the value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.last) |=> !busy)
      else $error("busy held after final character");

   // a minus sign is never the whole text
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_payload.character == CHAR_MINUS)) |-> !rsp_payload.last)
      else $error("minus sign flagged as final character");

   // only a minus sign or a decimal digit is sent
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_payload.character == CHAR_MINUS) ||
                      ((rsp_payload.character >= CHAR_ZERO) &&
                       (rsp_payload.character <= CHAR_ZERO + 8'd9))))
      else $error("character outside the decimal set");

endmodule

bind integer_to_decimal_ascii_unit itda_checker u_itda_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_strobe  (rsp_strobe),
   .rsp_payload (rsp_payload)
);

FILE: test/tb.sv
`timescale 1ns / 1ps

// Testbench for the binary to decimal ASCII converter.
// Each value handed over is also run through a local model of the conversion. The
// characters that the model expects wait in a queue. Every strobed character is
// compared with the head of that queue, field by field.
module tb;
   import itda_pkg::*;

   localparam int unsigned     VALUE_WIDTH  = 64;
   localparam int unsigned     HALF_PERIOD  = 4;
   localparam int unsigned     RESET_CYCLES = 12;
   // This tail outlasts the busy time of any value, so it catches any stray character.
   localparam int unsigned     TAIL_CYCLES  = 120;
   localparam int unsigned     RANDOM_ITEMS = 190;
   // The limit allows plenty over the slowest run: about 210 values, each busy and then idle for the longest gap.
   localparam longint unsigned CYCLE_LIMIT  = 600000;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         start       = 1'b0;
   logic         busy;
   itda_req_type req_payload = '0;
   logic         rsp_strobe;
   itda_rsp_type rsp_payload;

   // Characters still owed by the block, oldest first.
   itda_rsp_type    pending_chars[$];
   int unsigned     mismatches  = 0;
   longint unsigned cycle_count = 0;

   integer_to_decimal_ascii_unit #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // Work out the decimal text of one value and queue its characters.
   // Only the low VALUE_WIDTH bits count. In signed mode, a set top bit means a
   // negative value. Its magnitude is the unsigned negation within the width, so
   // the most negative value comes out right.
   function automatic void predict_text(input logic [63:0] raw, input logic mode);
      logic [63:0]  mask;
      logic [63:0]  magnitude;
      logic         negative;
      logic [7:0]   digit_chars[$];
      itda_rsp_type ch;
      mask      = {64{1'b1}} >> (64 - VALUE_WIDTH);
      magnitude = raw & mask;
      negative  = (mode == MODE_SIGNED) && magnitude[VALUE_WIDTH-1];
      if (negative) begin
         magnitude = (~magnitude + 64'd1) & mask;
      end
      // Peel digits off the least significant end. Zero still yields one digit.
      do begin
         digit_chars.push_front(CHAR_ZERO + 8'(magnitude % 64'd10));
         magnitude = magnitude / 64'd10;
      end while (magnitude != 64'd0);
      if (negative) begin
         ch.character = CHAR_MINUS;
         ch.last      = 1'b0;
         pending_chars.push_back(ch);
      end
      foreach (digit_chars[i]) begin
         ch.character = digit_chars[i];
         ch.last      = (i == digit_chars.size() - 1);
         pending_chars.push_back(ch);
      end
   endfunction

   function automatic logic [63:0] ten_power(input int unsigned exponent);
      logic [63:0] p;
      p = 64'd1;
      repeat (exponent) p = p * 64'd10;
      return p;
   endfunction

   // Idle gap before a transfer: mostly none or short, now and then long.
   // Long gaps let start rise at any point of the block's conversion.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 40);
      return $urandom_range(41, 200);
   endfunction

   // Pick a value that spreads over digit counts, powers of ten, signs and extremes.
   function automatic logic [63:0] pick_value();
      logic [63:0] v;
      int unsigned kind;
      kind = $urandom_range(0, 9);
      v    = {$urandom, $urandom};
      case (kind)
         0, 1, 2, 3: begin
            // Limit the magnitude so that every text length turns up.
            v = v >> (64 - $urandom_range(1, 64));
         end
         4, 5: begin
            // keep the full random pattern
         end
         6, 7: begin
            // Step across a digit-count boundary.
            v = ten_power($urandom_range(0, 19)) + 64'($urandom_range(0, 6)) - 64'd3;
         end
         8: begin
            // Small negative number in two's complement.
            v = ~64'($urandom_range(0, 1000)) + 64'd1;
         end
         default: begin
            // Hug the signed and unsigned extremes.
            if ($urandom_range(0, 1) == 0) v = {1'b1, 63'd0} + 64'($urandom_range(0, 5));
            else                           v = {64{1'b1}} - 64'($urandom_range(0, 5));
         end
      endcase
      return v;
   endfunction

   // Hand one value to the block after an idle gap. Return at the edge where the
   // transfer happens, with start still high, so that a following call with no
   // gap keeps it high without a second assignment in that step.
   task automatic issue_conversion(input logic [63:0] value, input logic mode,
                                   input int unsigned gap);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start             <= 1'b1;
      req_payload.value <= value;
      req_payload.mode  <= mode;
      // hold until the block is free at an edge
      do @(posedge clock); while (busy);
      predict_text(value, mode);
   endtask

   task automatic test_zero_and_single_digits();
      issue_conversion(64'd0, MODE_UNSIGNED, 0);
      issue_conversion(64'd0, MODE_SIGNED, pick_gap());
      issue_conversion(64'd7, MODE_UNSIGNED, pick_gap());
      issue_conversion(64'd9, MODE_SIGNED, 0);
      issue_conversion(64'd10, MODE_UNSIGNED, pick_gap());
   endtask

   task automatic test_unsigned_extremes();
      // all ones gives the longest text, twenty digits
      issue_conversion({64{1'b1}}, MODE_UNSIGNED, 0);
      issue_conversion(ten_power(19), MODE_UNSIGNED, pick_gap());
      issue_conversion(ten_power(19) - 64'd1, MODE_UNSIGNED, pick_gap());
      issue_conversion({1'b1, 63'd0}, MODE_UNSIGNED, 0);
      issue_conversion(64'd12345678901234567890, MODE_UNSIGNED, pick_gap());
   endtask

   task automatic test_signed_extremes();
      issue_conversion({64{1'b1}}, MODE_SIGNED, 0);
      // most negative value: sign plus nineteen digits, no overflow
      issue_conversion({1'b1, 63'd0}, MODE_SIGNED, pick_gap());
      issue_conversion({1'b0, {63{1'b1}}}, MODE_SIGNED, 0);
      issue_conversion({1'b0, {63{1'b1}}}, MODE_UNSIGNED, pick_gap());
      issue_conversion(~64'd10 + 64'd1, MODE_SIGNED, pick_gap());
      issue_conversion(~64'd9999999999 + 64'd1, MODE_SIGNED, 0);
   endtask

   task automatic test_back_to_back();
      // Alternate bit patterns with no gaps, so every input bit toggles.
      issue_conversion({32{2'b10}}, MODE_UNSIGNED, 0);
      issue_conversion({32{2'b01}}, MODE_SIGNED, 0);
      issue_conversion({32{2'b10}}, MODE_SIGNED, 0);
      issue_conversion({32{2'b01}}, MODE_UNSIGNED, 0);
      issue_conversion(64'd1, MODE_SIGNED, 0);
   endtask

   task automatic test_random_values();
      bit no_idle;
      no_idle = 1'b0;
      for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
         // Choose afresh between idling and an unbroken stream every twenty values.
         if (n % 20 == 0) no_idle = ($urandom_range(0, 2) == 0);
         issue_conversion(pick_value(), 1'($urandom_range(0, 1)),
                          no_idle ? 0 : pick_gap());
      end
   endtask

   // Compare each strobed character with the oldest owed one.
   always @(posedge clock) begin
      itda_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_chars.size() == 0) begin
            $error("character %0d last %0b strobed with nothing pending",
                   rsp_payload.character, rsp_payload.last);
            mismatches++;
         end else begin
            want = pending_chars.pop_front();
            if (rsp_payload.character !== want.character) begin
               $error("character: expected %0d, got %0d",
                      want.character, rsp_payload.character);
               mismatches++;
            end
            if (rsp_payload.last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_payload.last);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: drop the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[integer_to_decimal_ascii_unit] ERROR");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_zero_and_single_digits();
      test_unsigned_extremes();
      test_signed_extremes();
      test_back_to_back();
      test_random_values();
      start <= 1'b0;

      // Wait until every owed character has come. Then wait out the tail for strays.
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending_chars.size() == 0) begin
         $display("[integer_to_decimal_ascii_unit] OK");
      end else begin
         $display("[integer_to_decimal_ascii_unit] ERROR");
      end
      $finish;
   end

endmodule
